### rtl/ale_pkg.sv
// Shared types and constants for the array list engine.
`timescale 1ns / 1ps

package ale_pkg;

    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int OP_W  = 4;

    // Operation codes carried on the request tuser field.
    localparam logic [OP_W-1:0] OP_SELECT       = 4'd0;
    localparam logic [OP_W-1:0] OP_SEARCH       = 4'd1;
    localparam logic [OP_W-1:0] OP_INSERT       = 4'd2;
    localparam logic [OP_W-1:0] OP_INSERT_FRONT = 4'd3;
    localparam logic [OP_W-1:0] OP_INSERT_BACK  = 4'd4;
    localparam logic [OP_W-1:0] OP_REMOVE       = 4'd5;
    localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 4'd6;
    localparam logic [OP_W-1:0] OP_REMOVE_BACK  = 4'd7;
    localparam logic [OP_W-1:0] OP_REPLACE      = 4'd8;

    typedef struct packed {
        logic load;    // take the request into the datapath
        logic walk;    // step the memory walk
        logic finish;  // commit the count and load the result register
    } t_cmd;

    typedef struct packed {
        logic done;      // walk finished, nothing left in the read pipeline
        logic out_free;  // result register can take a new result
    } t_status;

endpackage

### rtl/ale_ctrl.sv
// Sequencing state machine for the array list engine.
`timescale 1ns / 1ps

module ale_ctrl
    import ale_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_req_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_st.done) begin
                    if (i_st.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                // The result waits here until the output register drains.
                if (i_st.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/ale_dp.sv
// Datapath of the array list engine: entry memory, count, walk pointer and result register.
`timescale 1ns / 1ps

module ale_dp
    import ale_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_st,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [POS_W-1:0]        i_position_in,
    input  logic signed [VAL_W-1:0] i_value_in,
    input  logic                    i_res_ready,
    output logic                    o_res_valid,
    output logic                    o_ok,
    output logic signed [VAL_W-1:0] o_value_out,
    output logic [POS_W-1:0]        o_position_out,
    output logic [POS_W-1:0]        o_count,
    output logic                    o_is_empty,
    output logic                    o_is_full
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [2:0] {
        K_NONE,
        K_SELECT,
        K_SEARCH,
        K_INSERT,
        K_REMOVE,
        K_REPLACE
    } t_kind;

    logic [VAL_W-1:0] mem [0:CAPACITY-1];

    logic [CW-1:0]    r_cnt;
    t_kind            r_kind;
    logic             r_ok;
    logic [PW-1:0]    r_at;
    logic [VAL_W-1:0] r_val;
    logic [PW-1:0]    r_idx;
    logic [CW-1:0]    r_left;
    logic             r_down;
    logic             r_rd_vld;
    logic [PW-1:0]    r_rd_idx;
    logic [VAL_W-1:0] r_rdata;
    logic             r_found;
    logic [PW-1:0]    r_fpos;

    logic             r_out_vld;
    logic             r_ok_q;
    logic [VAL_W-1:0] r_vout;
    logic [POS_W-1:0] r_pout;
    logic [POS_W-1:0] r_cout;
    logic             r_empty;
    logic             r_full;

    // Request decode.
    t_kind         n_kind;
    logic          n_ok;
    logic [PW-1:0] n_at;
    logic [PW-1:0] n_idx;
    logic [CW-1:0] n_left;
    logic          n_down;
    logic [PW-1:0] cnt_w;
    logic [PW-1:0] pos_w;
    logic [PW-1:0] cap_w;

    // Walk and result.
    logic          hit;
    logic          issue;
    logic          mv_we;
    logic [PW-1:0] mv_addr;
    logic          fin_we;
    logic [CW-1:0] n_cnt;
    logic [PW-1:0] n_cnt_w;
    logic [PW-1:0] pout_w;

    assign cnt_w = PW'(r_cnt);
    assign pos_w = PW'(i_position_in);
    assign cap_w = PW'(CAPACITY);

    always_comb begin
        n_kind = K_NONE;
        n_ok   = 1'b0;
        n_at   = '0;
        n_idx  = '0;
        n_left = '0;
        n_down = 1'b0;
        case (i_operation) inside
            OP_SELECT: begin
                n_kind = K_SELECT;
                n_ok   = (cnt_w != '0);
                // An index past the end reads the last entry.
                n_idx  = (pos_w < cnt_w) ? pos_w : cnt_w - PW'(1);
                n_left = n_ok ? CW'(1) : '0;
            end
            OP_SEARCH: begin
                n_kind = K_SEARCH;
                n_left = r_cnt;
            end
            OP_INSERT, OP_INSERT_FRONT, OP_INSERT_BACK: begin
                n_kind = K_INSERT;
                if (i_operation == OP_INSERT) begin
                    n_at = pos_w;
                end else if (i_operation == OP_INSERT_FRONT) begin
                    n_at = '0;
                end else begin
                    n_at = cnt_w;
                end
                n_ok   = (cnt_w < cap_w) && (n_at <= cnt_w);
                n_down = 1'b1;
                n_idx  = cnt_w - PW'(1);
                n_left = n_ok ? CW'(cnt_w - n_at) : '0;
            end
            OP_REMOVE, OP_REMOVE_FRONT, OP_REMOVE_BACK: begin
                n_kind = K_REMOVE;
                if (i_operation == OP_REMOVE) begin
                    n_at = pos_w;
                end else if (i_operation == OP_REMOVE_FRONT) begin
                    n_at = '0;
                end else begin
                    // On an empty list this wraps and fails the range check.
                    n_at = cnt_w - PW'(1);
                end
                n_ok   = (n_at < cnt_w);
                n_idx  = n_at + PW'(1);
                n_left = n_ok ? CW'(cnt_w - n_at - PW'(1)) : '0;
            end
            OP_REPLACE: begin
                n_kind = K_REPLACE;
                n_at   = pos_w;
                n_ok   = (pos_w < cnt_w);
            end
            default: begin
                n_kind = K_NONE;
            end
        endcase
    end

    assign hit   = r_rd_vld && (r_kind == K_SEARCH) && !r_found && (r_rdata == r_val);
    assign issue = i_cmd.walk && (r_left != '0) && !r_found && !hit;

    assign mv_we   = r_rd_vld && ((r_kind == K_INSERT) || (r_kind == K_REMOVE));
    assign mv_addr = r_down ? r_rd_idx + PW'(1) : r_rd_idx - PW'(1);
    assign fin_we  = i_cmd.finish && r_ok && ((r_kind == K_INSERT) || (r_kind == K_REPLACE));

    always_comb begin
        n_cnt = r_cnt;
        if (r_ok && (r_kind == K_INSERT)) begin
            n_cnt = r_cnt + CW'(1);
        end else if (r_ok && (r_kind == K_REMOVE)) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    assign n_cnt_w = PW'(n_cnt);
    assign pout_w  = r_found ? r_fpos : cnt_w;

    assign o_st.done     = !r_rd_vld && ((r_left == '0) || r_found);
    assign o_st.out_free = !r_out_vld || i_res_ready;

    // Entry memory: one read and one write a cycle, registered read data.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= mem[r_idx[AW-1:0]];
        end
        if (mv_we) begin
            mem[mv_addr[AW-1:0]] <= r_rdata;
        end else if (fin_we) begin
            mem[r_at[AW-1:0]] <= r_val;
        end
    end

    // Request registers and walk payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= n_kind;
            r_ok   <= n_ok;
            r_at   <= n_at;
            r_val  <= i_value_in;
            r_down <= n_down;
            r_idx  <= n_idx;
        end else if (issue) begin
            r_idx <= r_down ? r_idx - PW'(1) : r_idx + PW'(1);
        end
        if (issue) begin
            r_rd_idx <= r_idx;
        end
        if (hit) begin
            r_fpos <= r_rd_idx;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_left   <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (i_cmd.load) begin
                r_left  <= n_left;
                r_found <= 1'b0;
            end else begin
                if (issue) begin
                    r_left <= r_left - CW'(1);
                end
                if (hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_cnt <= n_cnt;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_ok_q  <= (r_kind == K_SEARCH) ? r_found : r_ok;
            r_vout  <= ((r_kind == K_SELECT) && r_ok) ? r_rdata : '0;
            r_pout  <= (r_kind == K_SEARCH) ? pout_w[POS_W-1:0] : '0;
            r_cout  <= n_cnt_w[POS_W-1:0];
            r_empty <= (n_cnt == '0);
            r_full  <= (n_cnt_w == cap_w);
        end
    end

    assign o_res_valid    = r_out_vld;
    assign o_ok           = r_ok_q;
    assign o_value_out    = r_vout;
    assign o_position_out = r_pout;
    assign o_count        = r_cout;
    assign o_is_empty     = r_empty;
    assign o_is_full      = r_full;

endmodule

### rtl/array_list_engine_unit.sv
// Top level of the array list engine: ordered list with insert, remove, search, select and replace.
//
//   channel   dir  handshake                  payload
//   request   in   i_s_tvalid / o_s_tready    i_s_tuser operation, i_s_tdata position, value
//   result    out  o_m_tvalid / i_m_tready    o_m_tdata ok, value, position, count, flags
//
// The walk reads entries from the entry memory, and the next request is taken once the walk
// has drained and its result is committed. Select reads one entry, search reads
// up to and including the match or the whole list, insert and remove read each entry they
// shift, and replace or a rejected request reads none. The result turns valid in the cycle
// the request side is ready again. The entry memory serves one read a cycle.
// Reset (synchronous, active low) empties the list; entries need no clearing.
// A finished result waits in the output register while the next request is taken; the
// request after that is held until the output register drains.
`timescale 1ns / 1ps

module array_list_engine_unit
    import ale_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // position_in[6:0], value_in[38:7], zero pad
    input  logic [3:0]  i_s_tuser,   // operation[3:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata    // ok[0], value_out[32:1], position_out[39:33],
                                     // count[46:40], is_empty[47], is_full[48], zero pad
);

    t_cmd    cmd;
    t_status st;

    logic                    ok;
    logic signed [VAL_W-1:0] value_out;
    logic [POS_W-1:0]        position_out;
    logic [POS_W-1:0]        count;
    logic                    is_empty;
    logic                    is_full;

    ale_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    ale_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_operation    (i_s_tuser),
        .i_position_in  (i_s_tdata[6:0]),
        .i_value_in     (i_s_tdata[38:7]),
        .i_res_ready    (i_m_tready),
        .o_res_valid    (o_m_tvalid),
        .o_ok           (ok),
        .o_value_out    (value_out),
        .o_position_out (position_out),
        .o_count        (count),
        .o_is_empty     (is_empty),
        .o_is_full      (is_full)
    );

    assign o_m_tdata = {7'd0, is_full, is_empty, count, position_out, value_out, ok};

`ifndef NO_ASSERTIONS
    // A result is committed only after the walk has drained and the output has room.
    a_finish_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (st.done && st.out_free))
        else $error("result committed before walk completed or output freed");

    // An accepted request keeps the engine busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while previous one still in work");

    // Every commit shows up as a valid result on the next cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_m_tvalid)
        else $error("committed result not presented");

    // The list cannot be empty and full at once.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(is_empty && is_full))
        else $error("empty and full flags both set");
`endif

endmodule
